/* rtl/lht_pkg.sv */
// Shared types and constants for the linear-probing key table.
package lht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_W       = 63;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = ADDR_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);

	// Modulo unit: key bits consumed per cycle, MSB first.
	localparam int MOD_STEP  = 7;
	localparam int MOD_ITERS = (KEY_W + MOD_STEP - 1) / MOD_STEP;
	localparam int MOD_PAD_W = MOD_ITERS * MOD_STEP;
	localparam int ITER_W    = (MOD_ITERS > 1) ? $clog2(MOD_ITERS) : 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_PROBE,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_t;

	typedef struct packed {
		logic              mark_en;
		logic              key_en;
		logic [ADDR_W-1:0] addr;
		mark_t             mark;
		logic [KEY_W-1:0]  key;
	} wr_t;

endpackage

/* rtl/lht_mod.sv */
// Multi-cycle key modulo table size unit, several remainder steps per cycle.
module lht_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lht_pkg::KEY_W-1:0]  key,
	input  logic [lht_pkg::SIZE_W-1:0] n,
	output logic                       done,
	output logic [lht_pkg::ADDR_W-1:0] rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [lht_pkg::ITER_W-1:0]    iter_q;
	logic [lht_pkg::MOD_PAD_W-1:0] sh_q;
	logic [lht_pkg::ADDR_W-1:0]    r_q;
	logic [lht_pkg::ADDR_W-1:0]    r_nxt;

	// Restoring remainder: r < n always, so {r,bit} < 2n and one subtract suffices.
	always_comb begin
		logic [lht_pkg::SIZE_W-1:0] t;
		r_nxt = r_q;
		for (int s = 0; s < lht_pkg::MOD_STEP; s++) begin
			t = {r_nxt, sh_q[lht_pkg::MOD_PAD_W-1-s]};
			if (t >= n)
				t = t - n;
			r_nxt = t[lht_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= !start && busy_q &&
				(iter_q == lht_pkg::ITER_W'(lht_pkg::MOD_ITERS - 1));
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == lht_pkg::ITER_W'(lht_pkg::MOD_ITERS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= lht_pkg::MOD_PAD_W'(key);
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << lht_pkg::MOD_STEP;
			r_q  <= r_nxt;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

/* rtl/lht_store.sv */
// Slot mark and slot key memories, with the mark clearing pass after reset.
module lht_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lht_pkg::rd_t              rd,
	input  lht_pkg::wr_t              wr,
	output lht_pkg::mark_t            rd_mark,
	output logic [lht_pkg::KEY_W-1:0] rd_key,
	output logic                      busy
);

	lht_pkg::mark_t            mark_mem [lht_pkg::TABLE_DEPTH];
	logic [lht_pkg::KEY_W-1:0] key_mem  [lht_pkg::TABLE_DEPTH];

	logic                       clr_q;
	logic [lht_pkg::ADDR_W-1:0] clr_addr_q;

	logic                       mark_we;
	logic [lht_pkg::ADDR_W-1:0] mark_wa;
	lht_pkg::mark_t             mark_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == lht_pkg::ADDR_W'(lht_pkg::TABLE_DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	always_comb begin
		if (clr_q) begin
			mark_we = 1'b1;
			mark_wa = clr_addr_q;
			mark_wd = lht_pkg::MARK_EMPTY;
		end else begin
			mark_we = wr.mark_en;
			mark_wa = wr.addr;
			mark_wd = wr.mark;
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[mark_wa] <= mark_wd;
		if (rd.en)
			rd_mark <= mark_mem[rd.addr];
	end

	always_ff @(posedge clk) begin
		if (wr.key_en)
			key_mem[wr.addr] <= wr.key;
		if (rd.en)
			rd_key <= key_mem[rd.addr];
	end

	assign busy = clr_q;

endmodule

/* rtl/lht_ctrl.sv */
// Request sequencer: start slot, probe walk, table update and result register.
module lht_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lht_pkg::SIZE_W-1:0] table_size,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  lht_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output lht_pkg::rsp_t              rsp,
	output logic                       mod_start,
	output logic [lht_pkg::KEY_W-1:0]  mod_key,
	output logic [lht_pkg::SIZE_W-1:0] mod_n,
	input  logic                       mod_done,
	input  logic [lht_pkg::ADDR_W-1:0] mod_rem,
	input  logic                       store_busy,
	output lht_pkg::rd_t               rd,
	output lht_pkg::wr_t               wr,
	input  lht_pkg::mark_t             rd_mark,
	input  logic [lht_pkg::KEY_W-1:0]  rd_key
);

	lht_pkg::state_t state_q, state_nxt;

	lht_pkg::op_t               op_q;
	logic [lht_pkg::KEY_W-1:0]  key_q;
	logic [lht_pkg::SIZE_W-1:0] n_q;
	logic [lht_pkg::ADDR_W-1:0] idx_q;
	logic [lht_pkg::ADDR_W-1:0] cnt_q;
	lht_pkg::rsp_t              res_q;
	lht_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;

	logic                       accept;
	logic                       op_ok;
	logic [lht_pkg::SIZE_W-1:0] n_in;
	logic [lht_pkg::SIZE_W-1:0] idx_inc;
	logic [lht_pkg::ADDR_W-1:0] idx_nxt;
	logic                       last;
	logic                       finish;
	logic                       rsp_free;
	lht_pkg::rsp_t              res;

	assign req_ready = (state_q == lht_pkg::S_IDLE) && !store_busy;
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		case (req.operation)
			lht_pkg::OP_INSERT, lht_pkg::OP_LOOKUP, lht_pkg::OP_REMOVE: op_ok = 1'b1;
			default: op_ok = 1'b0;
		endcase
	end

	// Size in use: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (table_size == '0)
			n_in = lht_pkg::SIZE_W'(1);
		else if (table_size > lht_pkg::SIZE_W'(lht_pkg::TABLE_DEPTH))
			n_in = lht_pkg::SIZE_W'(lht_pkg::TABLE_DEPTH);
		else
			n_in = table_size;
	end

	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign idx_nxt = (idx_inc == n_q) ? '0 : idx_inc[lht_pkg::ADDR_W-1:0];
	assign last    = ({1'b0, cnt_q} == n_q - 1'b1);

	// Verdict on the slot whose mark and key arrived this cycle.
	always_comb begin
		finish     = 1'b0;
		res.status = lht_pkg::STAT_MISSING;
		res.slot   = '0;
		case (op_q)
			lht_pkg::OP_INSERT: begin
				if (rd_mark != lht_pkg::MARK_USED) begin
					finish     = 1'b1;
					res.status = lht_pkg::STAT_OK;
					res.slot   = idx_q;
				end else if (last) begin
					finish     = 1'b1;
					res.status = lht_pkg::STAT_FULL;
				end
			end
			default: begin
				if (rd_mark == lht_pkg::MARK_USED && rd_key == key_q) begin
					finish     = 1'b1;
					res.status = lht_pkg::STAT_OK;
					res.slot   = idx_q;
				end else if (rd_mark == lht_pkg::MARK_EMPTY || last) begin
					finish = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lht_pkg::S_IDLE: begin
				if (accept)
					state_nxt = op_ok ? lht_pkg::S_MOD : lht_pkg::S_DONE;
			end
			lht_pkg::S_MOD: begin
				if (mod_done)
					state_nxt = lht_pkg::S_PROBE;
			end
			lht_pkg::S_PROBE: begin
				if (finish)
					state_nxt = lht_pkg::S_DONE;
			end
			lht_pkg::S_DONE: begin
				if (rsp_free)
					state_nxt = lht_pkg::S_IDLE;
			end
			default: state_nxt = lht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mod_start  = accept && op_ok;
		mod_key    = req.key;
		mod_n      = n_in;
		rd.en      = 1'b0;
		rd.addr    = idx_nxt;
		wr.mark_en = 1'b0;
		wr.key_en  = 1'b0;
		wr.addr    = idx_q;
		wr.mark    = lht_pkg::MARK_USED;
		wr.key     = key_q;
		case (state_q)
			lht_pkg::S_MOD: begin
				rd.en   = mod_done;
				rd.addr = mod_rem;
			end
			lht_pkg::S_PROBE: begin
				// next slot is fetched unless the walk ends here; a write only ends the walk
				rd.en = !finish;
				if (finish && res.status == lht_pkg::STAT_OK) begin
					case (op_q)
						lht_pkg::OP_INSERT: begin
							wr.mark_en = 1'b1;
							wr.key_en  = 1'b1;
						end
						lht_pkg::OP_REMOVE: begin
							wr.mark_en = 1'b1;
							wr.mark    = lht_pkg::MARK_DELETED;
						end
						default: wr.mark_en = 1'b0;
					endcase
				end
			end
			default: rd.en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lht_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == lht_pkg::S_DONE && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.operation;
			key_q        <= req.key;
			n_q          <= n_in;
			res_q.status <= lht_pkg::STAT_MISSING;
			res_q.slot   <= '0;
		end
		if (state_q == lht_pkg::S_MOD && mod_done) begin
			idx_q <= mod_rem;
			cnt_q <= '0;
		end
		if (state_q == lht_pkg::S_PROBE) begin
			if (finish)
				res_q <= res;
			else begin
				idx_q <= idx_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (state_q == lht_pkg::S_DONE && rsp_free)
			rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/linear_probe_hash_table.sv */
// Linear-probing key table: insert, lookup and remove of keys by open addressing.
//
// Request channel req_valid/req_ready/req carries an operation and a 63-bit key; the
// response channel rsp_valid/rsp_ready/rsp returns a status and a slot index, one
// beat per request, in request order. cfg_we/cfg_data writes table_size (slots in
// use); write it only while no request is outstanding.
// One request is worked at a time. From accept, a request passes through the
// key-modulo unit (7 key bits per cycle), the first slot read, and the probe walk
// over 1 to table_size slots, one slot per cycle from the mark/key memories,
// which have a registered read, then into the response register. The next request
// can be accepted at the edge after the response goes valid. Unknown operation
// codes go straight to S_DONE, which raises response valid once the register is free.
// After reset the slot marks are cleared one entry a cycle over all slots, and
// req_ready stays low until that pass is done; table_size resets to 1024.
// The response sits in its own register: a stalled receiver holds the beat
// while the next request is accepted and worked; that request then waits for
// the register to drain before it can finish.
module linear_probe_hash_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lht_pkg::SIZE_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  lht_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output lht_pkg::rsp_t              rsp
);

	logic [lht_pkg::SIZE_W-1:0] table_size_q;

	logic                       mod_start;
	logic [lht_pkg::KEY_W-1:0]  mod_key;
	logic [lht_pkg::SIZE_W-1:0] mod_n;
	logic                       mod_done;
	logic [lht_pkg::ADDR_W-1:0] mod_rem;
	logic                       store_busy;
	lht_pkg::rd_t               rd;
	lht_pkg::wr_t               wr;
	lht_pkg::mark_t             rd_mark;
	logic [lht_pkg::KEY_W-1:0]  rd_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_size_q <= lht_pkg::SIZE_RESET;
		else if (cfg_we)
			table_size_q <= cfg_data;
	end

	lht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (mod_key),
		.n      (mod_n),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	lht_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.rd_mark (rd_mark),
		.rd_key  (rd_key),
		.busy    (store_busy)
	);

	lht_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_size (table_size_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mod_start  (mod_start),
		.mod_key    (mod_key),
		.mod_n      (mod_n),
		.mod_done   (mod_done),
		.mod_rem    (mod_rem),
		.store_busy (store_busy),
		.rd         (rd),
		.wr         (wr),
		.rd_mark    (rd_mark),
		.rd_key     (rd_key)
	);

endmodule
